// File: design/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// Types and constants for the box against frustum plane culling block.
// ----------------------------------------------------------------------------
`default_nettype none

package afc_pkg;

  // number of plane registers that exist
  localparam int REG_COUNT = 6;

  // register index width and config address width (8 bytes per register)
  localparam int IDX_W  = 3;
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  // register indexes
  localparam logic [IDX_W-1:0] REG_PLANE_RIGHT  = 3'd0;
  localparam logic [IDX_W-1:0] REG_PLANE_LEFT   = 3'd1;
  localparam logic [IDX_W-1:0] REG_PLANE_BOTTOM = 3'd2;
  localparam logic [IDX_W-1:0] REG_PLANE_TOP    = 3'd3;
  localparam logic [IDX_W-1:0] REG_PLANE_FAR    = 3'd4;
  localparam logic [IDX_W-1:0] REG_PLANE_NEAR   = 3'd5;

  // field slots inside a plane word: a, b, c are the normal, d the offset
  localparam int FIELD_A = 0;
  localparam int FIELD_B = 1;
  localparam int FIELD_C = 2;
  localparam int FIELD_D = 3;
  localparam int AXES    = 3;

  localparam int COORD_W  = 16;
  localparam int CORNER_W = COORD_W + 1;
  localparam int PROD_W   = COORD_W + CORNER_W;
  localparam int SUM_W    = PROD_W + 2;
  // d is an integer, the normal is Q1.14
  localparam int D_SHIFT  = 14;

  typedef logic [FIELD_D:0][COORD_W-1:0] plane_t;

endpackage

`default_nettype wire

// File: design/aabb_frustum_cull.sv
// ----------------------------------------------------------------------------
// aabb_frustum_cull
// Axis-aligned box against frustum planes, p-vertex / n-vertex test.
// Four register ranks that move independently: input, corner add, multiply, sum.
// Throughput: one item per cycle unless out_stall holds the pipe.
// Reset clears all valids and sets every plane register to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_frustum_cull #(
  parameter int PLANE_COUNT = 6
) (
  input  wire                              clk,
  input  wire                              rst_n,

  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [afc_pkg::ADDR_W-1:0]       paddr,
  input  wire  [afc_pkg::DATA_W-1:0]       pwdata,
  output logic [afc_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,

  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  signed [afc_pkg::COORD_W-1:0] in_pos_x,
  input  wire  signed [afc_pkg::COORD_W-1:0] in_pos_y,
  input  wire  signed [afc_pkg::COORD_W-1:0] in_pos_z,
  input  wire  signed [afc_pkg::COORD_W-1:0] in_box_min_x,
  input  wire  signed [afc_pkg::COORD_W-1:0] in_box_min_y,
  input  wire  signed [afc_pkg::COORD_W-1:0] in_box_min_z,
  input  wire  signed [afc_pkg::COORD_W-1:0] in_box_max_x,
  input  wire  signed [afc_pkg::COORD_W-1:0] in_box_max_y,
  input  wire  signed [afc_pkg::COORD_W-1:0] in_box_max_z,

  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_visible,
  output logic                             out_fully_inside
);

  localparam int NT = (PLANE_COUNT < afc_pkg::REG_COUNT) ? PLANE_COUNT : afc_pkg::REG_COUNT;
  localparam int AXES = afc_pkg::AXES;

  // --------------------------------------------------------------------------
  // plane registers
  // --------------------------------------------------------------------------
  afc_pkg::plane_t                 plane_r [afc_pkg::REG_COUNT];
  logic                            cfg_wr;
  logic [afc_pkg::IDX_W-1:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[afc_pkg::ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < afc_pkg::REG_COUNT; i++) begin
        plane_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      case (cfg_idx)
        afc_pkg::REG_PLANE_RIGHT:  plane_r[0] <= pwdata;
        afc_pkg::REG_PLANE_LEFT:   plane_r[1] <= pwdata;
        afc_pkg::REG_PLANE_BOTTOM: plane_r[2] <= pwdata;
        afc_pkg::REG_PLANE_TOP:    plane_r[3] <= pwdata;
        afc_pkg::REG_PLANE_FAR:    plane_r[4] <= pwdata;
        afc_pkg::REG_PLANE_NEAR:   plane_r[5] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      afc_pkg::REG_PLANE_RIGHT:  prdata = plane_r[0];
      afc_pkg::REG_PLANE_LEFT:   prdata = plane_r[1];
      afc_pkg::REG_PLANE_BOTTOM: prdata = plane_r[2];
      afc_pkg::REG_PLANE_TOP:    prdata = plane_r[3];
      afc_pkg::REG_PLANE_FAR:    prdata = plane_r[4];
      afc_pkg::REG_PLANE_NEAR:   prdata = plane_r[5];
      default:                   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline control: each rank moves when the next one is free
  // --------------------------------------------------------------------------
  logic in_v_r, cor_v_r, prod_v_r, out_valid_r;
  logic in_rdy, cor_rdy, prod_rdy, out_rdy;

  assign out_rdy  = !out_valid_r || !out_stall;
  assign prod_rdy = !prod_v_r || out_rdy;
  assign cor_rdy  = !cor_v_r || prod_rdy;
  assign in_rdy   = !in_v_r || cor_rdy;
  assign in_stall = !in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      cor_v_r     <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_rdy)   in_v_r      <= in_valid;
      if (cor_rdy)  cor_v_r     <= in_v_r;
      if (prod_rdy) prod_v_r    <= cor_v_r;
      if (out_rdy)  out_valid_r <= prod_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // rank 1: input register
  // --------------------------------------------------------------------------
  logic signed [afc_pkg::COORD_W-1:0] pos_r [AXES];
  logic signed [afc_pkg::COORD_W-1:0] min_r [AXES];
  logic signed [afc_pkg::COORD_W-1:0] max_r [AXES];

  always_ff @(posedge clk) begin
    if (in_valid && in_rdy) begin
      pos_r[0] <= in_pos_x;
      pos_r[1] <= in_pos_y;
      pos_r[2] <= in_pos_z;
      min_r[0] <= in_box_min_x;
      min_r[1] <= in_box_min_y;
      min_r[2] <= in_box_min_z;
      max_r[0] <= in_box_max_x;
      max_r[1] <= in_box_max_y;
      max_r[2] <= in_box_max_z;
    end
  end

  // --------------------------------------------------------------------------
  // rank 2: world-space corners
  // --------------------------------------------------------------------------
  logic signed [afc_pkg::CORNER_W-1:0] lo_nxt [AXES];
  logic signed [afc_pkg::CORNER_W-1:0] hi_nxt [AXES];
  logic signed [afc_pkg::CORNER_W-1:0] lo_r   [AXES];
  logic signed [afc_pkg::CORNER_W-1:0] hi_r   [AXES];

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      lo_nxt[k] = afc_pkg::CORNER_W'(pos_r[k]) + afc_pkg::CORNER_W'(min_r[k]);
      hi_nxt[k] = afc_pkg::CORNER_W'(pos_r[k]) + afc_pkg::CORNER_W'(max_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (in_v_r && cor_rdy) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // rank 3: per plane p/n-vertex selection and products
  // rank 4: per plane sums, sign tests and reduction
  // --------------------------------------------------------------------------
  logic signed [afc_pkg::PROD_W-1:0] pprod_r [NT][AXES];
  logic signed [afc_pkg::PROD_W-1:0] nprod_r [NT][AXES];
  logic [NT-1:0]                     p_ok;
  logic [NT-1:0]                     n_ok;

  for (genvar p = 0; p < NT; p++) begin : g_plane
    logic signed [afc_pkg::PROD_W-1:0] pprod_nxt [AXES];
    logic signed [afc_pkg::PROD_W-1:0] nprod_nxt [AXES];
    logic signed [afc_pkg::SUM_W-1:0]  d_term;
    logic signed [afc_pkg::SUM_W-1:0]  p_sum;
    logic signed [afc_pkg::SUM_W-1:0]  n_sum;

    always_comb begin
      for (int k = 0; k < AXES; k++) begin
        // negative normal component: p-vertex takes the min corner
        if (plane_r[p][k][afc_pkg::COORD_W-1]) begin
          pprod_nxt[k] = afc_pkg::PROD_W'($signed(plane_r[p][k]))
                       * afc_pkg::PROD_W'(lo_r[k]);
          nprod_nxt[k] = afc_pkg::PROD_W'($signed(plane_r[p][k]))
                       * afc_pkg::PROD_W'(hi_r[k]);
        end else begin
          pprod_nxt[k] = afc_pkg::PROD_W'($signed(plane_r[p][k]))
                       * afc_pkg::PROD_W'(hi_r[k]);
          nprod_nxt[k] = afc_pkg::PROD_W'($signed(plane_r[p][k]))
                       * afc_pkg::PROD_W'(lo_r[k]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (cor_v_r && prod_rdy) begin
        pprod_r[p] <= pprod_nxt;
        nprod_r[p] <= nprod_nxt;
      end
    end

    assign d_term = afc_pkg::SUM_W'($signed(plane_r[p][afc_pkg::FIELD_D])) <<< afc_pkg::D_SHIFT;
    assign p_sum  = afc_pkg::SUM_W'(pprod_r[p][afc_pkg::FIELD_A])
                  + afc_pkg::SUM_W'(pprod_r[p][afc_pkg::FIELD_B])
                  + afc_pkg::SUM_W'(pprod_r[p][afc_pkg::FIELD_C]) + d_term;
    assign n_sum  = afc_pkg::SUM_W'(nprod_r[p][afc_pkg::FIELD_A])
                  + afc_pkg::SUM_W'(nprod_r[p][afc_pkg::FIELD_B])
                  + afc_pkg::SUM_W'(nprod_r[p][afc_pkg::FIELD_C]) + d_term;

    // zero counts as inside
    assign p_ok[p] = !p_sum[afc_pkg::SUM_W-1];
    assign n_ok[p] = !n_sum[afc_pkg::SUM_W-1];
  end

  logic visible_nxt, inside_nxt;
  logic visible_r, inside_r;

  assign visible_nxt = &p_ok;
  assign inside_nxt  = visible_nxt && (&n_ok);

  always_ff @(posedge clk) begin
    if (prod_v_r && out_rdy) begin
      visible_r <= visible_nxt;
      inside_r  <= inside_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_visible      = visible_r;
  assign out_fully_inside = inside_r;

endmodule

`default_nettype wire

// File: design/afc_checker.sv
// ----------------------------------------------------------------------------
// afc_checker
// Port-level checks for the frustum culling block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module afc_checker (
  input wire clk,
  input wire rst_n,
  input wire in_stall,
  input wire out_valid,
  input wire out_stall,
  input wire out_visible,
  input wire out_fully_inside
);

  // a culled box is never reported as fully inside
  a_inside_implies_visible: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_visible || !out_fully_inside))
    else $error("fully_inside set on a culled item");

  // with the result slot free the whole pipe moves, so no back pressure
  a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while output side is free");

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result stays and holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_visible) && $stable(out_fully_inside)))
    else $error("stalled result changed");

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_visible      (out_visible),
  .out_fully_inside (out_fully_inside)
);

`default_nettype wire

// File: tb/tb_aabb_frustum_cull.sv
// ----------------------------------------------------------------------------
// tb_aabb_frustum_cull
// Self-checking bench for the box against frustum plane culling block. Boxes
// stream in under random gaps and output stalls; a local integer model of the
// p-vertex / n-vertex test predicts visible and fully_inside for every item.
// Plane registers are written and read back through the config port between
// phases, covering zero, extreme and random frustums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_aabb_frustum_cull;

  localparam int PLANES     = 6;
  localparam int TESTED     = (PLANES < afc_pkg::REG_COUNT) ? PLANES : afc_pkg::REG_COUNT;
  localparam int LATENCY    = 3;
  localparam int LIMIT      = 1000000;
  localparam int ONE        = 16384;
  localparam int RAND_ITEMS = 1850;
  localparam int BATCHES    = 10;

  typedef struct packed {
    logic [afc_pkg::AXES-1:0][afc_pkg::COORD_W-1:0] pos;
    logic [afc_pkg::AXES-1:0][afc_pkg::COORD_W-1:0] lo_ofs;
    logic [afc_pkg::AXES-1:0][afc_pkg::COORD_W-1:0] hi_ofs;
  } box_t;

  typedef struct packed {
    logic visible;
    logic full_in;
  } cull_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                       psel, penable, pwrite;
  logic [afc_pkg::ADDR_W-1:0] paddr;
  logic [afc_pkg::DATA_W-1:0] pwdata;
  logic [afc_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  logic in_valid;
  logic in_stall;
  box_t in_box;

  logic out_valid;
  logic out_stall = 1'b0;
  logic out_visible;
  logic out_fully_inside;

  afc_pkg::plane_t plane_shadow [afc_pkg::REG_COUNT];
  cull_result_t    expected_q [$];

  bit idle_en    = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;
  int error_count = 0;
  int items_sent = 0;
  int seen_visible = 0;
  int seen_inside = 0;
  int seen_culled = 0;

  aabb_frustum_cull #(.PLANE_COUNT(PLANES)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pos_x         (in_box.pos[0]),
    .in_pos_y         (in_box.pos[1]),
    .in_pos_z         (in_box.pos[2]),
    .in_box_min_x     (in_box.lo_ofs[0]),
    .in_box_min_y     (in_box.lo_ofs[1]),
    .in_box_min_z     (in_box.lo_ofs[2]),
    .in_box_max_x     (in_box.hi_ofs[0]),
    .in_box_max_y     (in_box.hi_ofs[1]),
    .in_box_max_z     (in_box.hi_ofs[2]),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_visible      (out_visible),
    .out_fully_inside (out_fully_inside)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  function automatic int rnd_range(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic afc_pkg::plane_t make_plane(int a, int b, int c, int d);
    afc_pkg::plane_t p;
    p[afc_pkg::FIELD_A] = 16'(a);
    p[afc_pkg::FIELD_B] = 16'(b);
    p[afc_pkg::FIELD_C] = 16'(c);
    p[afc_pkg::FIELD_D] = 16'(d);
    return p;
  endfunction

  function automatic box_t make_box(int px, int py, int pz, int nx, int ny, int nz,
                                    int xx, int xy, int xz);
    box_t b;
    b.pos    = {16'(pz), 16'(py), 16'(px)};
    b.lo_ofs = {16'(nz), 16'(ny), 16'(nx)};
    b.hi_ofs = {16'(xz), 16'(xy), 16'(xx)};
    return b;
  endfunction

  // exact integer plane test, values in units of 2^-14
  function automatic cull_result_t predict_cull(box_t b);
    cull_result_t r;
    longint lo [afc_pkg::AXES];
    longint hi [afc_pkg::AXES];
    longint comp, p_val, n_val;
    r.visible = 1'b1;
    r.full_in = 1'b1;
    for (int k = 0; k < afc_pkg::AXES; k++) begin
      lo[k] = longint'(signed'(b.pos[k])) + longint'(signed'(b.lo_ofs[k]));
      hi[k] = longint'(signed'(b.pos[k])) + longint'(signed'(b.hi_ofs[k]));
    end
    for (int i = 0; i < TESTED && r.visible; i++) begin
      p_val = longint'(signed'(plane_shadow[i][afc_pkg::FIELD_D]))
            * (longint'(1) << afc_pkg::D_SHIFT);
      n_val = p_val;
      for (int k = 0; k < afc_pkg::AXES; k++) begin
        comp = longint'(signed'(plane_shadow[i][k]));
        // p-vertex takes max where the normal component is non-negative
        if (comp >= 0) begin
          p_val += comp * hi[k];
          n_val += comp * lo[k];
        end else begin
          p_val += comp * lo[k];
          n_val += comp * hi[k];
        end
      end
      if (p_val < 0) begin
        r.visible = 1'b0;
        r.full_in = 1'b0;
      end else if (n_val < 0) begin
        r.full_in = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // output stall generator
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap() - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    cull_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = expected_q.pop_front();
        if (out_visible !== want.visible)
          report_mismatch($sformatf("visible got %b want %b", out_visible, want.visible));
        if (out_fully_inside !== want.full_in)
          report_mismatch($sformatf("fully_inside got %b want %b", out_fully_inside,
                                    want.full_in));
        if (want.visible) seen_visible++;
        else seen_culled++;
        if (want.full_in) seen_inside++;
      end
    end
  end

  // called at a rising edge; returns at the edge that accepts the item
  task automatic send_box(box_t b);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 9) < 3) gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_box   <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_q.push_back(predict_cull(b));
    items_sent++;
  endtask

  // lower valid and let the pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // write one plane, then read it back
  task automatic write_plane(logic [afc_pkg::IDX_W-1:0] idx, afc_pkg::plane_t val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    plane_shadow[idx] = val;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== val)
      report_mismatch($sformatf("plane %0d read back %h want %h", idx, prdata, val));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_frustum(afc_pkg::plane_t pr, afc_pkg::plane_t pl,
                               afc_pkg::plane_t pb, afc_pkg::plane_t pt,
                               afc_pkg::plane_t pf, afc_pkg::plane_t pn);
    write_plane(afc_pkg::REG_PLANE_RIGHT, pr);
    write_plane(afc_pkg::REG_PLANE_LEFT, pl);
    write_plane(afc_pkg::REG_PLANE_BOTTOM, pb);
    write_plane(afc_pkg::REG_PLANE_TOP, pt);
    write_plane(afc_pkg::REG_PLANE_FAR, pf);
    write_plane(afc_pkg::REG_PLANE_NEAR, pn);
  endtask

  // zero planes after reset: everything visible and fully inside
  task automatic test_reset_planes();
    send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768,
                      32767, 32767, 32767));
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768,
                      -32768, -32768, -32768));
    drain();
  endtask

  // axis-aligned frustum |x|,|y| <= 1000, 10 <= z <= 5000
  task automatic test_box_frustum();
    write_frustum(make_plane(-ONE, 0, 0, 1000), make_plane(ONE, 0, 0, 1000),
                  make_plane(0, ONE, 0, 1000), make_plane(0, -ONE, 0, 1000),
                  make_plane(0, 0, -ONE, 5000), make_plane(0, 0, ONE, -10));
    send_box(make_box(0, 0, 100, -10, -10, -10, 10, 10, 10));
    send_box(make_box(995, 0, 100, -10, -10, -10, 10, 10, 10));
    send_box(make_box(2000, 0, 100, -10, -10, -10, 10, 10, 10));
    // max corner exactly on the right plane
    send_box(make_box(990, 0, 100, -10, -10, -10, 10, 10, 10));
    // min corner on the plane, then one past it
    send_box(make_box(1000, 0, 100, 0, 0, 0, 5, 5, 5));
    send_box(make_box(1001, 0, 100, 0, 0, 0, 5, 5, 5));
    // min above max, no swap
    send_box(make_box(0, 0, 100, 20, 20, 20, -20, -20, -20));
    send_box(make_box(-2000, 0, 100, -10, -10, -10, 10, 10, 10));
    send_box(make_box(0, -2000, 100, -10, -10, -10, 10, 10, 10));
    send_box(make_box(0, 2000, 100, -10, -10, -10, 10, 10, 10));
    send_box(make_box(0, 0, 5000, -10, -10, -10, 0, 10, 0));
    send_box(make_box(0, 0, 6000, -10, -10, -10, 10, 10, 10));
    send_box(make_box(0, 0, 0, -5, -5, -5, 5, 5, 5));
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767,
                      32767, 32767, 32767));
    drain();
  endtask

  // extreme plane words, including every field at its limits
  task automatic test_extreme_planes();
    write_frustum(make_plane(-1, -1, -1, -1),
                  make_plane(-32768, -32768, -32768, 32767),
                  make_plane(32767, 32767, 32767, -32768),
                  make_plane(0, 0, 0, 0),
                  make_plane(32767, -32768, 32767, 32767),
                  make_plane(0, 0, 0, -32768));
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768,
                      -32768, -32768, -32768));
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767,
                      32767, 32767, 32767));
    drain();
    write_plane(afc_pkg::REG_PLANE_RIGHT, make_plane(0, 0, 0, 0));
    write_plane(afc_pkg::REG_PLANE_NEAR, make_plane(0, 0, 0, 32767));
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768,
                      -32768, -32768, -32768));
    send_box(make_box(0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();
  endtask

  function automatic int rnd_component(bit wild);
    int r;
    if (!wild) return rnd_range(-4000, 4000);
    r = $urandom_range(0, 3);
    if (r == 0) return -32768;
    else if (r == 1) return 32767;
    else if (r == 2) return 0;
    else return rnd_range(-32768, 32767);
  endfunction

  task automatic load_random_frustum(int kind);
    int ex, ey, zn, zf;
    ex = rnd_range(200, 2000);
    ey = rnd_range(200, 2000);
    zn = rnd_range(1, 200);
    zf = zn + rnd_range(100, 6000);
    case (kind)
      0: write_frustum(
           make_plane(-ONE, rnd_component(0), rnd_component(0), ex),
           make_plane(ONE, rnd_component(0), rnd_component(0), ex),
           make_plane(rnd_component(0), ONE, rnd_component(0), ey),
           make_plane(rnd_component(0), -ONE, rnd_component(0), ey),
           make_plane(rnd_component(0), rnd_component(0), -ONE, zf),
           make_plane(rnd_component(0), rnd_component(0), ONE, -zn));
      1: begin
        for (int i = 0; i < afc_pkg::REG_COUNT; i++)
          write_plane(afc_pkg::IDX_W'(i),
                      make_plane(rnd_range(-32768, 32767), rnd_range(-32768, 32767),
                                 rnd_range(-32768, 32767), rnd_range(-2000, 4000)));
      end
      2: begin
        for (int i = 0; i < afc_pkg::REG_COUNT; i++)
          write_plane(afc_pkg::IDX_W'(i), afc_pkg::plane_t'({$urandom, $urandom}));
      end
      3: write_frustum('0, '0, '0, '0, '0, '0);
      default: begin
        for (int i = 0; i < afc_pkg::REG_COUNT; i++)
          write_plane(afc_pkg::IDX_W'(i),
                      make_plane(rnd_component(1), rnd_component(1),
                                 rnd_component(1), rnd_component(1)));
      end
    endcase
  endtask

  function automatic box_t random_box();
    int r;
    int p [afc_pkg::AXES];
    int lo [afc_pkg::AXES];
    int hi [afc_pkg::AXES];
    logic [159:0] raw;
    r = $urandom_range(0, 99);
    if (r >= 80 && r < 90) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      return box_t'(raw[$bits(box_t)-1:0]);
    end
    for (int k = 0; k < afc_pkg::AXES; k++) begin
      p[k]  = (k == 2) ? rnd_range(-500, 7000) : rnd_range(-2500, 2500);
      lo[k] = -rnd_range(0, 600);
      hi[k] = rnd_range(0, 600);
    end
    // min above max now and then
    if (r >= 90) return make_box(p[0], p[1], p[2], hi[0], hi[1], hi[2], lo[0], lo[1], lo[2]);
    return make_box(p[0], p[1], p[2], lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  task automatic test_random_frustums();
    for (int batch = 0; batch < BATCHES; batch++) begin
      load_random_frustum(batch % 5);
      idle_en = (batch % 4 != 3);
      for (int n = 0; n < RAND_ITEMS / BATCHES; n++) send_box(random_box());
      drain();
    end
    idle_en = 1'b0;
  endtask

  initial begin
    rst_n    = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    in_box   = '0;
    for (int i = 0; i < afc_pkg::REG_COUNT; i++) plane_shadow[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_en = 1'b1;

    test_reset_planes();
    test_box_frustum();
    test_extreme_planes();
    test_random_frustums();

    drain();
    $display("%0d boxes over zero, axis-aligned, tilted, random and extreme frustums",
             items_sent);
    $display("results: %0d visible (%0d fully inside), %0d culled", seen_visible,
             seen_inside, seen_culled);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/afc_pkg.sv
design/aabb_frustum_cull.sv
design/afc_checker.sv
tb/tb_aabb_frustum_cull.sv
